FILE: design/lpfs_pkg.sv
// Shared types and constants for the scan point frame synchronizer.
package lpfs_pkg;

    // Field widths of the item and result beats
    localparam int REQ_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 10;
    localparam int EVENT_W = 2;
    localparam int COUNT_W = 11;
    localparam int ANGLE_W = 15;
    localparam int DIST_W  = 16;
    localparam int POINT_W = 40;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int MINP_W     = 10;
    localparam int TICK_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

    localparam logic [MINP_W-1:0] MIN_POINTS_RST    = 10'd400;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd3000;

    // Alignment search constants
    localparam logic [BYTE_W-1:0] ALIGN_MASK  = 8'h11;
    localparam logic [BYTE_W-1:0] ALIGN_MATCH = 8'h10;
    localparam logic [2:0]        SKIP_LAST   = 3'd2;
    localparam logic [2:0]        POINT_LAST  = 3'd4;

    typedef enum logic [REQ_W-1:0] {
        REQ_BYTE = 2'd0,
        REQ_TICK = 2'd1,
        REQ_READ = 2'd2
    } req_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_FRAME    = 2'd0,
        EV_OVERFLOW = 2'd1,
        EV_TIMEOUT  = 2'd2,
        EV_READ     = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        ALIGN_SEEK  = 2'd0,
        ALIGN_CHECK = 2'd1,
        ALIGN_SKIP  = 2'd2
    } align_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [COUNT_W-1:0] point_count;
        logic [BYTE_W-1:0]  quality;
        logic [ANGLE_W-1:0] angle_q6;
        logic [DIST_W-1:0]  distance_raw;
    } out_item_t;

endpackage

FILE: design/lpfs_if.sv
// Valid/ready channel interfaces for request beats and result beats.
interface lpfs_in_if;
    import lpfs_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface lpfs_out_if;
    import lpfs_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: design/lpfs_ram.sv
// Generic single-port RAM with registered read data.
module lpfs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: design/lidar_point_frame_sync.sv
// A result beat passes through stage 1 and then the output register before it is offered.
// Throughput: one request beat per cycle while the result channel does not stall; the single-port point store
//   takes either one point write (byte beats) or one read (read beats) per cycle.
// Reset: alignment, frame and counters clear at once and the configuration registers take their defaults;
//   the point store is not cleared, so entries never written read back undefined.
// No clearing pass: the block accepts beats from the first cycle after reset.
module lidar_point_frame_sync #(
    parameter int STORE_POINTS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    lpfs_in_if.sink                            req_ch,
    lpfs_out_if.source                         res_ch,
    input  logic                               cfg_we,
    input  logic [lpfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpfs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import lpfs_pkg::*;

    localparam int AW = $clog2(STORE_POINTS);
    localparam int CW = $clog2(STORE_POINTS + 1);
    localparam logic [CW-1:0] LAST_COUNT = CW'(STORE_POINTS - 1);
    localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

    // Configuration registers
    logic [MINP_W-1:0] min_points_reg;
    logic [TICK_W-1:0] timeout_ticks_reg;

    // Sync state
    logic          aligned_reg, aligned_next;
    logic          active_reg, active_next;
    align_t        phase_reg, phase_next;
    logic [2:0]    pos_reg, pos_next;
    logic [31:0]   asm_reg, asm_next;
    logic [CW-1:0] count_reg, count_next;
    logic [TICK_W-1:0] tick_reg, tick_next;

    // Result pipeline
    logic               s1_valid_reg;
    event_t             s1_event_reg;
    logic [COUNT_W-1:0] s1_count_reg;
    logic               s1_zero_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    // Decoded beat
    logic              acc, is_byte, is_tick, is_read;
    logic [BYTE_W-1:0] b;
    logic [POINT_W-1:0] point;
    logic pt_done, pt_start, cnt_over;
    logic frame_open, frame_close, frame_short, pt_store, overflow;
    logic [TICK_W-1:0] tick_inc;
    logic timeout, lose, ev_valid, read_in_range;
    event_t ev_code;
    logic s1_move, out_load;

    // Store port
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_addr;
    logic [POINT_W-1:0] ram_rdata;

    assign acc     = req_ch.valid && req_ch.ready;
    assign is_byte = acc && (req_ch.item.req_type == REQ_BYTE);
    assign is_tick = acc && (req_ch.item.req_type == REQ_TICK);
    assign is_read = acc && (req_ch.item.req_type == REQ_READ);
    assign b       = req_ch.item.data_byte;
    assign point   = {b, asm_reg};

    // Point completion and frame decisions
    assign pt_done  = is_byte && aligned_reg && (pos_reg == POINT_LAST);
    assign pt_start = asm_reg[0] && !asm_reg[1] && asm_reg[8];
    assign cnt_over = 32'(count_reg) > 32'(min_points_reg);

    assign frame_open  = pt_done && !active_reg && pt_start;
    assign frame_close = pt_done && active_reg && pt_start && cnt_over;
    assign frame_short = pt_done && active_reg && pt_start && !cnt_over;
    assign pt_store    = pt_done && active_reg && !pt_start;
    assign overflow    = pt_store && (count_reg == LAST_COUNT);

    assign tick_inc = tick_reg + TICK_W'(1);
    assign timeout  = is_tick && (tick_inc >= timeout_ticks_reg);
    assign lose     = frame_short || overflow || timeout;

    assign read_in_range = 32'(req_ch.item.read_index) < 32'(STORE_POINTS);

    // Writes come only from byte beats and reads only from read beats, so the
    // two never meet in one cycle; a read right after a write sees the new data.
    assign ram_we   = frame_open || frame_close || pt_store;
    assign ram_re   = is_read;
    assign ram_addr = ram_we ? ((frame_open || frame_close) ? '0 : count_reg[AW-1:0])
                             : AW'(req_ch.item.read_index);

    lpfs_ram #(
        .WIDTH (POINT_W),
        .DEPTH (STORE_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (point),
        .rdata (ram_rdata)
    );

    // Next sync state
    always_comb
    begin
        aligned_next = aligned_reg;
        active_next  = active_reg;
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        asm_next     = asm_reg;
        count_next   = count_reg;
        tick_next    = tick_reg;

        if (is_byte && !aligned_reg)
        begin
            unique case (phase_reg)
                ALIGN_SEEK:
                begin
                    if ((b & ALIGN_MASK) == ALIGN_MATCH)
                    begin
                        phase_next = ALIGN_CHECK;
                    end
                end
                ALIGN_CHECK:
                begin
                    if (b[0])
                    begin
                        phase_next = ALIGN_SKIP;
                        pos_next   = '0;
                    end
                    else
                    begin
                        phase_next = ALIGN_SEEK;
                    end
                end
                ALIGN_SKIP:
                begin
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg == SKIP_LAST)
                    begin
                        aligned_next = 1'b1;
                        phase_next   = ALIGN_SEEK;
                        pos_next     = '0;
                        count_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = ALIGN_SEEK;
                end
            endcase
        end
        else if (is_byte)
        begin
            if (pos_reg != POINT_LAST)
            begin
                asm_next[pos_reg[1:0]*8 +: 8] = b;
                pos_next = pos_reg + 3'd1;
            end
            else
            begin
                pos_next = '0;
                if (frame_open)
                begin
                    active_next = 1'b1;
                    count_next  = ONE_COUNT;
                end
                if (frame_close)
                begin
                    count_next = ONE_COUNT;
                end
                if (pt_store)
                begin
                    count_next = count_reg + ONE_COUNT;
                end
            end
        end

        if (is_tick)
        begin
            tick_next = tick_inc;
        end
        if (frame_close || overflow || timeout)
        begin
            tick_next = '0;
        end

        // Drop alignment and the frame
        if (lose)
        begin
            aligned_next = 1'b0;
            active_next  = 1'b0;
            phase_next   = ALIGN_SEEK;
            pos_next     = '0;
            count_next   = '0;
        end
    end

    // Result code of the beat
    always_comb
    begin
        ev_valid = 1'b1;
        ev_code  = EV_READ;
        if (frame_close)
        begin
            ev_code = EV_FRAME;
        end
        else if (overflow)
        begin
            ev_code = EV_OVERFLOW;
        end
        else if (timeout)
        begin
            ev_code = EV_TIMEOUT;
        end
        else if (!is_read)
        begin
            ev_valid = 1'b0;
        end
    end

    // Handshake: advance s1 when the output register frees up
    assign s1_move      = s1_valid_reg && (!out_valid_reg || res_ch.ready);
    assign req_ch.ready = !s1_valid_reg || s1_move;
    assign out_load     = !out_valid_reg || res_ch.ready;

    assign res_ch.valid = out_valid_reg;
    assign res_ch.item  = out_item_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_points_reg    <= MIN_POINTS_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_POINTS:    min_points_reg    <= cfg_wdata[MINP_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata[TICK_W-1:0];
                default:           min_points_reg    <= min_points_reg;
            endcase
        end
    end

    // Sync state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aligned_reg <= 1'b0;
            active_reg  <= 1'b0;
            phase_reg   <= ALIGN_SEEK;
            pos_reg     <= '0;
            asm_reg     <= '0;
            count_reg   <= '0;
            tick_reg    <= '0;
        end
        else
        begin
            aligned_reg <= aligned_next;
            active_reg  <= active_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            asm_reg     <= asm_next;
            count_reg   <= count_next;
            tick_reg    <= tick_next;
        end
    end

    // Stage 1 and output valid control: stage 1 holds the beat while the store read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ch.ready)
            begin
                s1_valid_reg <= acc && ev_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (req_ch.ready)
        begin
            s1_event_reg <= ev_code;
            s1_count_reg <= frame_close ? COUNT_W'(count_reg) : '0;
            s1_zero_reg  <= !read_in_range;
        end
    end

    // Output payload: unpack the read point, or zeros for events and out-of-range reads
    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_item_reg.event_res   <= s1_event_reg;
            out_item_reg.point_count <= s1_count_reg;
            if ((s1_event_reg == EV_READ) && !s1_zero_reg)
            begin
                out_item_reg.quality      <= ram_rdata[7:0];
                out_item_reg.angle_q6     <= {ram_rdata[23:16], ram_rdata[15:9]};
                out_item_reg.distance_raw <= {ram_rdata[39:32], ram_rdata[31:24]};
            end
            else
            begin
                out_item_reg.quality      <= '0;
                out_item_reg.angle_q6     <= '0;
                out_item_reg.distance_raw <= '0;
            end
        end
    end

    // Store port is never written and read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("point store written and read in one cycle");

    // Fill count stays inside the store
    assert property (@(posedge clk) disable iff (!rst_n) 32'(count_reg) < 32'(STORE_POINTS))
        else $error("stored point count beyond store depth");

    // Without alignment there is no open frame and no stored point
    assert property (@(posedge clk) disable iff (!rst_n)
        !aligned_reg |-> (!active_reg && (count_reg == '0)))
        else $error("frame state left over without alignment");

    // Reported events restart the tick counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_close || overflow || timeout) |=> (tick_reg == '0))
        else $error("tick counter not restarted after event");

    // A stalled stage 1 issues no new store read, so its read data holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> !ram_re)
        else $error("store read issued while stage 1 stalled");

endmodule
